[sv/lcgi_pkg.sv]
// Shared types and constants for the LED colour gradient interpolator.
package lcgi_pkg;

  localparam int POS_W  = 6;
  localparam int CHAN_W = 8;
  localparam int IDX_W  = 5;
  localparam int NUM_CH = 3;

  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [CHAN_W-1:0] chan_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef chan_t [NUM_CH-1:0] rgb_t;

  // Request to the shared divider: one channel difference over the span.
  typedef struct packed {
    logic  start;
    chan_t dividend;
    pos_t  divisor;
  } div_req_t;

  // Divider answer, valid for the single cycle in which done is high.
  typedef struct packed {
    logic  done;
    chan_t quot;
    pos_t  rem;
  } div_rsp_t;

endpackage

[sv/led_color_gradient_interp.sv]
// Top level of the LED colour gradient interpolator: sequencer, lanes and output word register.
// A first point goes straight to emitting words once it is accepted; a later point
// first spends three divisions, one per channel, on the shared divider.
// Words leave at one per cycle while the output is taken, so a point gives up to 64 words
// after the division phase; the block takes one point at a time.
// Reset (synchronous, rst_n low) forgets the previous point and empties the output register.
module led_color_gradient_interp #(
  parameter int LEDS_PER_STRIP = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [5:0] in_position,
  input  logic [7:0] in_red,
  input  logic [7:0] in_green,
  input  logic [7:0] in_blue,
  input  logic       in_last_point,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_strip,
  output logic [4:0] out_led_index,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic       out_run_end
);
  import lcgi_pkg::*;

  // Highest position on the two strips together.
  localparam pos_t LAST_POS = POS_W'(2 * LEDS_PER_STRIP - 1);
  localparam pos_t STRIP_LEN = POS_W'(LEDS_PER_STRIP);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       have_r, have_nxt;
  pos_t       prev_pos_r, prev_pos_nxt;
  rgb_t       to_r, to_nxt;
  rgb_t       from_r, from_nxt;
  pos_t       pos_r, pos_nxt;
  pos_t       end_r, end_nxt;
  pos_t       cur_r, cur_nxt;
  pos_t       den_r, den_nxt;
  logic       interp_r, interp_nxt;
  logic [1:0] ch_r, ch_nxt;
  logic       sent_r, sent_nxt;
  rgb_t       qd_r, qd_nxt;
  pos_t       rd_r [NUM_CH];
  pos_t       rd_nxt [NUM_CH];
  rgb_t       mag_r, mag_nxt;
  pos_t       acc_r [NUM_CH];
  pos_t       acc_nxt [NUM_CH];

  logic       out_valid_r, out_valid_nxt;
  logic       strip_r;
  idx_t       idx_r;
  rgb_t       col_r;
  logic       run_end_r;

  pos_t       clamp_pos;
  logic       accept;
  logic       ignore_pt;
  logic       load;
  logic       cur_strip;
  idx_t       cur_idx;
  rgb_t       col_w;
  logic [NUM_CH-1:0] up;
  rgb_t       absdiff;
  rgb_t       step_mag;
  pos_t       step_acc [NUM_CH];
  div_req_t   div_req;
  div_rsp_t   div_rsp;

  // Positions beyond the strips are pulled back to the last LED.
  assign clamp_pos = (in_position > LAST_POS) ? LAST_POS : in_position;
  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  // A later point that does not move forward is dropped without any effect.
  assign ignore_pt = have_r && (clamp_pos <= prev_pos_r);
  assign load      = (state_r == ST_EMIT) && (!out_valid_r || out_ready);

  assign cur_strip = (cur_r >= STRIP_LEN);
  assign cur_idx   = cur_strip ? IDX_W'(cur_r - STRIP_LEN) : IDX_W'(cur_r);

  // Each channel's interpolation is kept as a magnitude that grows by
  // |diff| / den per LED, with the remainder accumulated so that the
  // magnitude is always floor(|diff| * num / den). Adding or subtracting it
  // from the start colour then truncates toward zero, as required.
  always_comb begin
    for (int k = 0; k < NUM_CH; k++) begin
      logic [CHAN_W:0]  msum;
      logic [POS_W:0]   rsum;
      logic             wrap;
      up[k]      = (to_r[k] >= from_r[k]);
      absdiff[k] = up[k] ? chan_t'(to_r[k] - from_r[k]) : chan_t'(from_r[k] - to_r[k]);
      msum       = {1'b0, mag_r[k]} + {1'b0, qd_r[k]};
      rsum       = {1'b0, acc_r[k]} + {1'b0, rd_r[k]};
      wrap       = rsum >= {1'b0, den_r};
      step_acc[k] = wrap ? POS_W'(rsum - {1'b0, den_r}) : rsum[POS_W-1:0];
      step_mag[k] = CHAN_W'(msum + {{CHAN_W{1'b0}}, wrap});
      if (interp_r && (cur_r <= pos_r)) begin
        col_w[k] = up[k] ? chan_t'(from_r[k] + step_mag[k])
                         : chan_t'(from_r[k] - step_mag[k]);
      end else begin
        col_w[k] = to_r[k];
      end
    end
  end

  assign div_req.start    = (state_r == ST_DIV) && !sent_r;
  assign div_req.dividend = absdiff[ch_r];
  assign div_req.divisor  = den_r;

  lcgi_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  always_comb begin
    state_nxt     = state_r;
    have_nxt      = have_r;
    prev_pos_nxt  = prev_pos_r;
    to_nxt        = to_r;
    from_nxt      = from_r;
    pos_nxt       = pos_r;
    end_nxt       = end_r;
    cur_nxt       = cur_r;
    den_nxt       = den_r;
    interp_nxt    = interp_r;
    ch_nxt        = ch_r;
    sent_nxt      = sent_r;
    qd_nxt        = qd_r;
    rd_nxt        = rd_r;
    mag_nxt       = mag_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r && !out_ready;

    case (state_r)
      ST_IDLE: begin
        if (accept && !ignore_pt) begin
          from_nxt     = to_r;
          to_nxt       = {in_blue, in_green, in_red};
          pos_nxt      = clamp_pos;
          end_nxt      = in_last_point ? LAST_POS : clamp_pos;
          interp_nxt   = have_r;
          cur_nxt      = have_r ? POS_W'(prev_pos_r + 1'b1) : '0;
          den_nxt      = POS_W'(clamp_pos - prev_pos_r);
          prev_pos_nxt = clamp_pos;
          have_nxt     = !in_last_point;
          ch_nxt       = '0;
          sent_nxt     = 1'b0;
          mag_nxt      = '0;
          for (int k = 0; k < NUM_CH; k++) begin
            acc_nxt[k] = '0;
          end
          state_nxt    = have_r ? ST_DIV : ST_EMIT;
        end
      end
      ST_DIV: begin
        if (!sent_r) begin
          sent_nxt = 1'b1;
        end
        if (div_rsp.done) begin
          qd_nxt[ch_r] = div_rsp.quot;
          rd_nxt[ch_r] = div_rsp.rem;
          sent_nxt     = 1'b0;
          if (ch_r == 2'(NUM_CH - 1)) begin
            state_nxt = ST_EMIT;
          end else begin
            ch_nxt = ch_r + 1'b1;
          end
        end
      end
      ST_EMIT: begin
        if (load) begin
          out_valid_nxt = 1'b1;
          mag_nxt       = step_mag;
          acc_nxt       = step_acc;
          if (cur_r == end_r) begin
            state_nxt = ST_IDLE;
          end else begin
            cur_nxt = cur_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      have_r      <= 1'b0;
      prev_pos_r  <= '0;
      to_r        <= '0;
      out_valid_r <= 1'b0;
      sent_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      have_r      <= have_nxt;
      prev_pos_r  <= prev_pos_nxt;
      to_r        <= to_nxt;
      out_valid_r <= out_valid_nxt;
      sent_r      <= sent_nxt;
    end
    from_r   <= from_nxt;
    pos_r    <= pos_nxt;
    end_r    <= end_nxt;
    cur_r    <= cur_nxt;
    den_r    <= den_nxt;
    interp_r <= interp_nxt;
    ch_r     <= ch_nxt;
    qd_r     <= qd_nxt;
    rd_r     <= rd_nxt;
    mag_r    <= mag_nxt;
    acc_r    <= acc_nxt;
    if (load) begin
      strip_r   <= cur_strip;
      idx_r     <= cur_idx;
      col_r     <= col_w;
      run_end_r <= (cur_r == end_r);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_strip     = strip_r;
  assign out_led_index = idx_r;
  assign out_red       = col_r[0];
  assign out_green     = col_r[1];
  assign out_blue      = col_r[2];
  assign out_run_end   = run_end_r;

endmodule

[sv/lcgi_div.sv]
// Restoring divider, one quotient bit per cycle, shared by the three channels.
module lcgi_div (
  input  logic              clk,
  input  logic              rst_n,
  input  lcgi_pkg::div_req_t req,
  output lcgi_pkg::div_rsp_t rsp
);
  import lcgi_pkg::*;

  localparam int CNT_W = $clog2(CHAN_W);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  chan_t            dvd_r, dvd_nxt;
  pos_t             dsr_r, dsr_nxt;
  pos_t             rem_r, rem_nxt;
  logic [POS_W:0]   trial;
  logic             fits;

  // The partial remainder stays below the divisor, so the shifted trial
  // value needs only one more bit.
  assign trial = {rem_r, dvd_r[CHAN_W-1]};
  assign fits  = trial >= {1'b0, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    rem_nxt  = rem_r;
    if (req.start && !busy_r) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = req.dividend;
      dsr_nxt  = req.divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = fits ? POS_W'(trial - {1'b0, dsr_r}) : trial[POS_W-1:0];
      dvd_nxt = {dvd_r[CHAN_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(CHAN_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = dvd_r;
  assign rsp.rem  = rem_r;

endmodule

[sv/lcgi_checker.sv]
// Port-level checks for the LED colour gradient interpolator, bound to the top level.
module lcgi_checker #(
  parameter int LEDS_PER_STRIP = 32
) (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_strip,
  input logic [4:0] out_led_index,
  input logic [7:0] out_red,
  input logic [7:0] out_green,
  input logic [7:0] out_blue,
  input logic       out_run_end
);

  // A stalled word keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_led_index) && $stable(out_strip)
      && $stable(out_red) && $stable(out_green) && $stable(out_blue) && $stable(out_run_end))
    else $error("output word changed while stalled");

  // While a run is still unfinished the block takes no new point.
  a_busy_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_run_end |-> !in_ready)
    else $error("input ready in the middle of a run");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_led_index) < LEDS_PER_STRIP))
    else $error("LED index beyond strip length");

  // The last LED of the second strip always closes a run.
  a_last_led_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_strip && (32'(out_led_index) == LEDS_PER_STRIP - 1) |-> out_run_end)
    else $error("last LED without run end");

endmodule

bind led_color_gradient_interp lcgi_checker #(.LEDS_PER_STRIP(LEDS_PER_STRIP)) u_lcgi_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_strip    (out_strip),
  .out_led_index(out_led_index),
  .out_red      (out_red),
  .out_green    (out_green),
  .out_blue     (out_blue),
  .out_run_end  (out_run_end)
);

[bench/tb_top.sv]
// Self-checking bench for the LED colour gradient interpolator: directed points, random frames.
`timescale 1ns / 1ps

module tb_top;
  import lcgi_pkg::*;

  // Two strips of 32 LEDs each, so positions run 0 to 63.
  localparam int LEDS  = 32;
  localparam int TOTAL = 2 * LEDS;
  // Limit on the whole run, set well above what a correct run needs, even with heavy output stalls.
  localparam int CYCLE_LIMIT = 1_000_000;
  // Drain time after the last expected word, well above the three divisions of a later point.
  localparam int DRAIN_CYCLES = 100;
  localparam int HOLD_CYCLES = 400;

  // One painted LED as it should leave the block.
  typedef struct {
    logic  strip;
    idx_t  idx;
    chan_t red;
    chan_t green;
    chan_t blue;
    logic  run_end;
  } led_word_t;

  logic  clk;
  logic  rst_n         = 1'b0;
  logic  in_valid      = 1'b0;
  logic  in_ready;
  pos_t  in_position   = '0;
  chan_t in_red        = '0;
  chan_t in_green      = '0;
  chan_t in_blue       = '0;
  logic  in_last_point = 1'b0;
  logic  out_valid;
  logic  out_ready     = 1'b0;
  logic  out_strip;
  idx_t  out_led_index;
  chan_t out_red;
  chan_t out_green;
  chan_t out_blue;
  logic  out_run_end;

  // Idling percentages for the two channels, and the long output hold-off.
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  logic hold_off      = 1'b0;

  int fault_count    = 0;
  int cycle_count    = 0;
  int points_painted = 0;

  // Painted LEDs that are still to come out of the block, oldest first.
  led_word_t pending_leds[$];
  led_word_t seen_led;
  led_word_t want_led;

  // Our copy of the previous control point and whether a frame is open.
  pos_t  prev_pos   = '0;
  chan_t prev_red   = '0;
  chan_t prev_green = '0;
  chan_t prev_blue  = '0;
  bit    frame_open = 1'b0;

  led_color_gradient_interp #(
    .LEDS_PER_STRIP(LEDS)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_position  (in_position),
    .in_red       (in_red),
    .in_green     (in_green),
    .in_blue      (in_blue),
    .in_last_point(in_last_point),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_strip    (out_strip),
    .out_led_index(out_led_index),
    .out_red      (out_red),
    .out_green    (out_green),
    .out_blue     (out_blue),
    .out_run_end  (out_run_end)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // The receiver stalls at random, and all the time while the hold-off is in force.
  always @(posedge clk) begin
    out_ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
  end

  // A run that hangs is a failure in its own right.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d words still expected", cycle_count,
               pending_leds.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // Counts every fault; only the first ten are described in full.
  function automatic void note_fault(string what);
    fault_count++;
    if (fault_count <= 10) $display("%0t: %s", $realtime, what);
  endfunction

  // One channel on the straight line between two points. The division truncates toward
  // zero, so a falling channel rounds up rather than down.
  function automatic chan_t blend_channel(chan_t from, chan_t to, int num, int den);
    int v;
    v = int'(from) + ((int'(to) - int'(from)) * num) / den;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return chan_t'(v);
  endfunction

  function automatic void queue_led(int p, chan_t r, chan_t g, chan_t b);
    led_word_t w;
    w.strip   = (p >= LEDS);
    w.idx     = idx_t'(p % LEDS);
    w.red     = r;
    w.green   = g;
    w.blue    = b;
    w.run_end = 1'b0;
    pending_leds.push_back(w);
  endfunction

  // Works out every LED that an accepted control point paints and returns how many.
  function automatic int paint_point(pos_t pos, chan_t r, chan_t g, chan_t b, logic last);
    int first_word;
    int den;
    first_word = pending_leds.size();
    // A point that does not move forward within an open frame is dropped whole.
    if (frame_open && pos <= prev_pos) return 0;
    if (!frame_open) begin
      for (int p = 0; p <= int'(pos); p++) queue_led(p, r, g, b);
    end else begin
      den = int'(pos) - int'(prev_pos);
      for (int p = int'(prev_pos) + 1; p <= int'(pos); p++) begin
        queue_led(p, blend_channel(prev_red, r, p - int'(prev_pos), den),
                  blend_channel(prev_green, g, p - int'(prev_pos), den),
                  blend_channel(prev_blue, b, p - int'(prev_pos), den));
      end
    end
    // The final point of a frame carries its own colour on to the end of the second strip.
    if (last) begin
      for (int p = int'(pos) + 1; p < TOTAL; p++) queue_led(p, r, g, b);
    end
    if (pending_leds.size() > first_word) pending_leds[pending_leds.size() - 1].run_end = 1'b1;
    prev_pos   = pos;
    prev_red   = r;
    prev_green = g;
    prev_blue  = b;
    frame_open = !last;
    return pending_leds.size() - first_word;
  endfunction

  // Offers one control point, holds it until it is taken and then predicts its LEDs.
  // Valid is left high on return so that a following point can go out back to back.
  task automatic send_point(input pos_t pos, input chan_t r, input chan_t g, input chan_t b,
                            input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_position   <= pos;
    in_red        <= r;
    in_green      <= g;
    in_blue       <= b;
    in_last_point <= last;
    do @(posedge clk); while (!in_ready);
    if (paint_point(pos, r, g, b, last) > 0) points_painted++;
  endtask

  // Channel values lean towards the extremes, where wrap and clamp trouble would show.
  function automatic chan_t random_channel();
    case ($urandom_range(3))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return chan_t'($urandom_range(255));
    endcase
  endfunction

  // Checks every word the block hands over against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      seen_led.strip   = out_strip;
      seen_led.idx     = out_led_index;
      seen_led.red     = out_red;
      seen_led.green   = out_green;
      seen_led.blue    = out_blue;
      seen_led.run_end = out_run_end;
      if (pending_leds.size() == 0) begin
        note_fault($sformatf("unexpected word strip %0d led %0d rgb %0d/%0d/%0d end %0d",
                             seen_led.strip, seen_led.idx, seen_led.red, seen_led.green,
                             seen_led.blue, seen_led.run_end));
      end else begin
        want_led = pending_leds.pop_front();
        if (seen_led.strip !== want_led.strip || seen_led.idx !== want_led.idx ||
            seen_led.red !== want_led.red || seen_led.green !== want_led.green ||
            seen_led.blue !== want_led.blue || seen_led.run_end !== want_led.run_end) begin
          note_fault($sformatf({"mismatch: expected strip %0d led %0d rgb %0d/%0d/%0d end %0d,",
                                " got strip %0d led %0d rgb %0d/%0d/%0d end %0d"},
                               want_led.strip, want_led.idx, want_led.red, want_led.green,
                               want_led.blue, want_led.run_end, seen_led.strip, seen_led.idx,
                               seen_led.red, seen_led.green, seen_led.blue,
                               seen_led.run_end));
        end
      end
    end
  end

  // A lone first point at position zero, then a last point at the far end with every
  // channel falling or rising across the whole span.
  task automatic test_first_point();
    send_point(6'd0, 8'd255, 8'd0, 8'd128, 1'b0);
    send_point(6'd63, 8'd0, 8'd255, 8'd127, 1'b1);
  endtask

  // A first point that is also last paints all 64 LEDs in one colour; so does a later frame
  // whose only point sits mid-way.
  task automatic test_last_fill();
    send_point(6'd0, 8'd17, 8'd34, 8'd51, 1'b1);
    send_point(6'd40, 8'd1, 8'd2, 8'd3, 1'b1);
  endtask

  // Points at or below the previous position are dropped, even when marked last; the frame
  // then goes on from the earlier point, first by a single step.
  task automatic test_ignored_points();
    send_point(6'd20, 8'd200, 8'd10, 8'd90, 1'b0);
    send_point(6'd20, 8'd0, 8'd0, 8'd0, 1'b1);
    send_point(6'd7, 8'd255, 8'd255, 8'd255, 1'b1);
    send_point(6'd21, 8'd0, 8'd255, 8'd91, 1'b0);
    send_point(6'd30, 8'd100, 8'd3, 8'd250, 1'b1);
  endtask

  // Runs across the boundary between the two strips, with full-scale swings both ways.
  task automatic test_strip_edges();
    send_point(6'd31, 8'd255, 8'd255, 8'd255, 1'b0);
    send_point(6'd32, 8'd0, 8'd0, 8'd0, 1'b0);
    send_point(6'd62, 8'd255, 8'd0, 8'd255, 1'b0);
    send_point(6'd63, 8'd0, 8'd255, 8'd0, 1'b1);
  endtask

  // Mostly well-formed frames of rising points with random colours, some with a stray
  // backward point inside; the rest are lone points at any position.
  task automatic test_random_traffic(input int painted_target, input int send_pct,
                                     input int recv_pct);
    int   goal;
    int   points;
    pos_t pos;
    logic last;
    int   next_pos;
    goal          = points_painted + painted_target;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    while (points_painted < goal) begin
      if ($urandom_range(5) == 0) begin
        pos  = pos_t'($urandom_range(TOTAL - 1));
        last = 1'($urandom_range(1));
        points = 1;
      end else begin
        pos    = pos_t'($urandom_range(20));
        last   = 1'b0;
        points = $urandom_range(1, 6);
      end
      for (int j = 0; j < points; j++) begin
        if (points > 1) last = (j == points - 1) && ($urandom_range(9) != 0);
        // A point left open at the far end would lock out every later point of the frame.
        if (pos == pos_t'(TOTAL - 1)) last = 1'b1;
        send_point(pos, random_channel(), random_channel(), random_channel(), last);
        if (last) break;
        if ($urandom_range(7) == 0) begin
          send_point(pos_t'($urandom_range(int'(pos))), random_channel(), random_channel(),
                     random_channel(), 1'($urandom_range(1)));
        end
        next_pos = int'(pos) + $urandom_range(1, 20);
        pos      = pos_t'((next_pos > TOTAL - 1) ? TOTAL - 1 : next_pos);
      end
    end
    // Close any frame left open so that the next test starts from a clean state.
    if (frame_open) send_point(pos_t'(TOTAL - 1), random_channel(), random_channel(),
                               random_channel(), 1'b1);
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering a whole frame,
  // so the output fills and the block stops taking points.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    fork
      begin
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
      end
      begin
        send_point(6'd3, 8'd10, 8'd250, 8'd0, 1'b0);
        send_point(6'd15, 8'd240, 8'd5, 8'd255, 1'b0);
        send_point(6'd27, 8'd0, 8'd128, 8'd60, 1'b0);
        send_point(6'd40, 8'd255, 8'd255, 8'd1, 1'b0);
        send_point(6'd52, 8'd7, 8'd0, 8'd200, 1'b0);
        send_point(6'd60, 8'd99, 8'd180, 8'd33, 1'b1);
      end
    join
  endtask

  // A first point left open at the far end: nothing can follow it, so every later point is
  // dropped. This leaves the block locked until reset and therefore runs last.
  task automatic test_open_at_far_end();
    send_point(6'd63, 8'd77, 8'd0, 8'd255, 1'b0);
    send_point(6'd63, 8'd1, 8'd2, 8'd3, 1'b1);
    send_point(6'd10, 8'd4, 8'd5, 8'd6, 1'b0);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 21;
    recv_idle_pct = 79;
    test_first_point();
    test_last_fill();
    test_ignored_points();
    test_strip_edges();

    test_random_traffic(133, 21, 79);
    test_random_traffic(133, 79, 21);
    test_random_traffic(134, 0, 0);
    test_backpressure();
    test_open_at_far_end();
    in_valid <= 1'b0;

    while (pending_leds.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fault_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[led_color_gradient_interp.f]
sv/lcgi_pkg.sv
sv/lcgi_div.sv
sv/led_color_gradient_interp.sv
sv/lcgi_checker.sv
bench/tb_top.sv
